// ===== design/pit_pkg.sv =====
package pit_pkg;

    // coordinate width and the exact widths that follow from it
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;      // vertex differences
    localparam int PROD_W     = 2 * DIFF_W;          // one coordinate product
    localparam int DOT_W      = 2 * COORD_BITS + 4;  // three-term dot product
    localparam int MUL_W      = 2 * DOT_W;           // product of two dot products
    localparam int NUM_W      = MUL_W + 1;           // den, nu, nv
    localparam int CMP_W      = MUL_W + 3;           // nu + nv - den

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [DOT_W-1:0]      t_dot;
    typedef logic signed [MUL_W-1:0]      t_mul;
    typedef logic signed [NUM_W-1:0]      t_num;
    typedef logic signed [CMP_W-1:0]      t_cmp;

    typedef struct packed {
        t_coord vertex_a_x;
        t_coord vertex_a_y;
        t_coord vertex_a_z;
        t_coord vertex_b_x;
        t_coord vertex_b_y;
        t_coord vertex_b_z;
        t_coord vertex_c_x;
        t_coord vertex_c_y;
        t_coord vertex_c_z;
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
    } t_pit_in;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } t_pit_out;

    // stage enables for the split multiplier
    typedef struct packed {
        logic en_pp;
        logic en_sum;
    } t_pit_mul_ctl;

endpackage

// ===== design/pit_wide_mul.sv =====
module pit_wide_mul (
    input  logic                 i_clk,
    input  pit_pkg::t_pit_mul_ctl i_ctl,
    input  pit_pkg::t_dot        i_a,
    input  pit_pkg::t_dot        i_b,
    output pit_pkg::t_mul        o_p
);
    import pit_pkg::*;

    // split each operand into a signed high half and an unsigned low half
    localparam int LO_W = DOT_W / 2;
    localparam int HI_W = DOT_W - LO_W;

    logic signed [HI_W-1:0]      w_a_hi;
    logic signed [HI_W-1:0]      w_b_hi;
    logic        [LO_W-1:0]      w_a_lo;
    logic        [LO_W-1:0]      w_b_lo;

    logic signed [2*HI_W-1:0]    r_pp_hh;
    logic signed [HI_W+LO_W:0]   r_pp_hl;
    logic signed [HI_W+LO_W:0]   r_pp_lh;
    logic        [2*LO_W-1:0]    r_pp_ll;
    t_mul                        r_prod;

    assign w_a_hi = i_a[DOT_W-1:LO_W];
    assign w_b_hi = i_b[DOT_W-1:LO_W];
    assign w_a_lo = i_a[LO_W-1:0];
    assign w_b_lo = i_b[LO_W-1:0];

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_pp) begin
            r_pp_hh <= w_a_hi * w_b_hi;
            r_pp_hl <= w_a_hi * $signed({1'b0, w_b_lo});
            r_pp_lh <= $signed({1'b0, w_a_lo}) * w_b_hi;
            r_pp_ll <= w_a_lo * w_b_lo;
        end
    end

    // weighted sum of the partials
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_prod <= (t_mul'(r_pp_hh) <<< (2 * LO_W))
                    + (t_mul'(r_pp_hl) <<< LO_W)
                    + (t_mul'(r_pp_lh) <<< LO_W)
                    + t_mul'(r_pp_ll);
        end
    end

    assign o_p = r_prod;

endmodule

// ===== design/point_in_triangle_test.sv =====
// channel | handshake                  | payload
// --------+----------------------------+---------------------------------------
// in      | i_in_valid / o_in_ready    | i_in_data  : vertices a, b, c, point
// out     | o_out_valid / i_out_ready  | o_out_data : inside_res, degenerate
//
// one test per cycle while i_out_ready is high; a transfer in reaches
// o_out_valid through the seven-register pipeline (differences, coordinate
// products, dot products, partial products, wide products, numerators,
// flags)
// each stage has its own valid bit and holds only while it is full and the
// stage after it holds, so empty stages fill up and o_in_ready stays high
// while a finished result waits, unless every stage is full
// reset clears the valid bits only, payload registers are not reset
module point_in_triangle_test (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pit_pkg::t_pit_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pit_pkg::t_pit_out o_out_data
);
    import pit_pkg::*;

    // pipeline stage positions
    localparam int NUM_STG = 7;
    localparam int ST_DIFF = 0;
    localparam int ST_PROD = 1;
    localparam int ST_DOT  = 2;
    localparam int ST_PP   = 3;
    localparam int ST_MUL  = 4;
    localparam int ST_NUM  = 5;
    localparam int ST_OUT  = 6;

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG:0]   w_en;

    // ---------------------------------------------------------------
    // stage enables: a stage loads when it is empty or the next one loads
    // ---------------------------------------------------------------
    always_comb begin
        w_en[NUM_STG] = i_out_ready;
        for (int k = NUM_STG - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NUM_STG; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[ST_OUT];

    // ---------------------------------------------------------------
    // stage 1: edge vectors e0 = c - a, e1 = b - a and w = p - a
    // ---------------------------------------------------------------
    t_coord w_a [3];
    t_coord w_b [3];
    t_coord w_c [3];
    t_coord w_p [3];
    t_diff  r_e0 [3];
    t_diff  r_e1 [3];
    t_diff  r_w  [3];

    assign w_a[0] = i_in_data.vertex_a_x;
    assign w_a[1] = i_in_data.vertex_a_y;
    assign w_a[2] = i_in_data.vertex_a_z;
    assign w_b[0] = i_in_data.vertex_b_x;
    assign w_b[1] = i_in_data.vertex_b_y;
    assign w_b[2] = i_in_data.vertex_b_z;
    assign w_c[0] = i_in_data.vertex_c_x;
    assign w_c[1] = i_in_data.vertex_c_y;
    assign w_c[2] = i_in_data.vertex_c_z;
    assign w_p[0] = i_in_data.point_x;
    assign w_p[1] = i_in_data.point_y;
    assign w_p[2] = i_in_data.point_z;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DIFF]) begin
            for (int i = 0; i < 3; i++) begin
                r_e0[i] <= t_diff'(w_c[i]) - t_diff'(w_a[i]);
                r_e1[i] <= t_diff'(w_b[i]) - t_diff'(w_a[i]);
                r_w[i]  <= t_diff'(w_p[i]) - t_diff'(w_a[i]);
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 2: per-coordinate products for the five dot products
    // ---------------------------------------------------------------
    t_prod r_p00 [3];
    t_prod r_p01 [3];
    t_prod r_p02 [3];
    t_prod r_p11 [3];
    t_prod r_p12 [3];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PROD]) begin
            for (int i = 0; i < 3; i++) begin
                r_p00[i] <= r_e0[i] * r_e0[i];
                r_p01[i] <= r_e0[i] * r_e1[i];
                r_p02[i] <= r_e0[i] * r_w[i];
                r_p11[i] <= r_e1[i] * r_e1[i];
                r_p12[i] <= r_e1[i] * r_w[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 3: dot products d00, d01, d02, d11, d12
    // ---------------------------------------------------------------
    t_dot r_d00;
    t_dot r_d01;
    t_dot r_d02;
    t_dot r_d11;
    t_dot r_d12;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DOT]) begin
            r_d00 <= t_dot'(r_p00[0]) + t_dot'(r_p00[1]) + t_dot'(r_p00[2]);
            r_d01 <= t_dot'(r_p01[0]) + t_dot'(r_p01[1]) + t_dot'(r_p01[2]);
            r_d02 <= t_dot'(r_p02[0]) + t_dot'(r_p02[1]) + t_dot'(r_p02[2]);
            r_d11 <= t_dot'(r_p11[0]) + t_dot'(r_p11[1]) + t_dot'(r_p11[2]);
            r_d12 <= t_dot'(r_p12[0]) + t_dot'(r_p12[1]) + t_dot'(r_p12[2]);
        end
    end

    // ---------------------------------------------------------------
    // stages 4 and 5: six wide products, two registers each
    //   0: d00*d11  1: d01*d01  2: d11*d02  3: d01*d12  4: d00*d12  5: d01*d02
    // ---------------------------------------------------------------
    t_dot         w_op_a [6];
    t_dot         w_op_b [6];
    t_mul         w_mul  [6];
    t_pit_mul_ctl w_mul_ctl;

    assign w_op_a[0] = r_d00;
    assign w_op_b[0] = r_d11;
    assign w_op_a[1] = r_d01;
    assign w_op_b[1] = r_d01;
    assign w_op_a[2] = r_d11;
    assign w_op_b[2] = r_d02;
    assign w_op_a[3] = r_d01;
    assign w_op_b[3] = r_d12;
    assign w_op_a[4] = r_d00;
    assign w_op_b[4] = r_d12;
    assign w_op_a[5] = r_d01;
    assign w_op_b[5] = r_d02;

    assign w_mul_ctl.en_pp  = w_en[ST_PP];
    assign w_mul_ctl.en_sum = w_en[ST_MUL];

    for (genvar g = 0; g < 6; g++) begin : g_mul
        pit_wide_mul u_mul (
            .i_clk (i_clk),
            .i_ctl (w_mul_ctl),
            .i_a   (w_op_a[g]),
            .i_b   (w_op_b[g]),
            .o_p   (w_mul[g])
        );
    end

    // ---------------------------------------------------------------
    // stage 6: denominator and barycentric numerators
    // ---------------------------------------------------------------
    t_num r_den;
    t_num r_nu;
    t_num r_nv;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_NUM]) begin
            r_den <= t_num'(w_mul[0]) - t_num'(w_mul[1]);
            r_nu  <= t_num'(w_mul[2]) - t_num'(w_mul[3]);
            r_nv  <= t_num'(w_mul[4]) - t_num'(w_mul[5]);
        end
    end

    // ---------------------------------------------------------------
    // stage 7: inside when den > 0, nu >= 0, nv >= 0 and nu + nv < den
    // ---------------------------------------------------------------
    t_cmp     w_slack;
    logic     w_degen;
    logic     w_inside;
    t_pit_out r_out;

    assign w_slack  = t_cmp'(r_nu) + t_cmp'(r_nv) - t_cmp'(r_den);
    assign w_degen  = (r_den == '0);
    assign w_inside = !w_degen && !r_den[NUM_W-1] && !r_nu[NUM_W-1]
                   && !r_nv[NUM_W-1] && w_slack[CMP_W-1];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_out.inside_res <= w_inside;
            r_out.degenerate <= w_degen;
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== design/pit_checker.sv =====
module pit_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input pit_pkg::t_pit_out o_out_data
);
    import pit_pkg::*;

    // a held result keeps its value until the transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output result changed while stalled");

    // a degenerate triangle never reports inside
    a_degen_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.inside_res && o_out_data.degenerate))
        else $error("degenerate triangle reported inside");

    // input backpressure only when the output is stalled
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input refused without output stall");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // right after reset, no result is shown while an input is refused
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid || !i_in_valid || o_in_ready)
        else $error("result appeared straight out of reset");

endmodule

bind point_in_triangle_test pit_checker u_pit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/pit_verdict_check.sv =====
module pit_verdict_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  pit_pkg::t_pit_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  pit_pkg::t_pit_out i_out_data,
    output int                o_fail_count,
    output int                o_pending
);
    import pit_pkg::*;

    typedef logic signed [127:0] t_wide;

    t_pit_out expected_verdicts[$];
    t_pit_out want;
    int       fail_count;
    int       results_seen;

    function automatic longint as_long(input t_coord c);
        return c;
    endfunction

    function automatic longint dot3(input longint x0, input longint x1, input longint x2,
                                    input longint y0, input longint y1, input longint y2);
        return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    // exact barycentric test, no division
    function automatic t_pit_out predict_verdict(input t_pit_in t);
        longint   ax, ay, az;
        longint   abx, aby, abz, acx, acy, acz, apx, apy, apz;
        longint   d_cc, d_cb, d_cp, d_bb, d_bp;
        t_wide    den, nu, nv;
        t_pit_out v;
        ax  = as_long(t.vertex_a_x);
        ay  = as_long(t.vertex_a_y);
        az  = as_long(t.vertex_a_z);
        abx = as_long(t.vertex_b_x) - ax;
        aby = as_long(t.vertex_b_y) - ay;
        abz = as_long(t.vertex_b_z) - az;
        acx = as_long(t.vertex_c_x) - ax;
        acy = as_long(t.vertex_c_y) - ay;
        acz = as_long(t.vertex_c_z) - az;
        apx = as_long(t.point_x) - ax;
        apy = as_long(t.point_y) - ay;
        apz = as_long(t.point_z) - az;
        d_cc = dot3(acx, acy, acz, acx, acy, acz);
        d_cb = dot3(acx, acy, acz, abx, aby, abz);
        d_cp = dot3(acx, acy, acz, apx, apy, apz);
        d_bb = dot3(abx, aby, abz, abx, aby, abz);
        d_bp = dot3(abx, aby, abz, apx, apy, apz);
        den = t_wide'(d_cc) * t_wide'(d_bb) - t_wide'(d_cb) * t_wide'(d_cb);
        nu  = t_wide'(d_bb) * t_wide'(d_cp) - t_wide'(d_cb) * t_wide'(d_bp);
        nv  = t_wide'(d_cc) * t_wide'(d_bp) - t_wide'(d_cb) * t_wide'(d_cp);
        v.degenerate = (den == 0);
        v.inside_res = (den > 0) && (nu >= 0) && (nv >= 0) && (nu + nv < den);
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", results_seen, what);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("result %b/%b with no test waiting",
                                              i_out_data.inside_res, i_out_data.degenerate));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_out_data.inside_res !== want.inside_res)
                        report_mismatch($sformatf("inside_res %b, want %b",
                                                  i_out_data.inside_res, want.inside_res));
                    if (i_out_data.degenerate !== want.degenerate)
                        report_mismatch($sformatf("degenerate %b, want %b",
                                                  i_out_data.degenerate, want.degenerate));
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready)
                expected_verdicts.push_back(predict_verdict(i_in_data));
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_verdicts.size();
    end

endmodule

// ===== tb/tb_point_in_triangle_test.sv =====
module tb_point_in_triangle_test;
    import pit_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;  // far above the slowest legal run
    localparam int RANDOM_TESTS = 1200;
    localparam int TAIL_CYCLES  = 20;      // pipeline is 7 deep, plus margin

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_pit_in   in_data;
    logic      out_valid;
    logic      out_ready;
    t_pit_out  out_data;
    int        fail_count;
    int        pending;
    int        cycle_count;
    logic      steady_run;  // when set, neither side idles

    point_in_triangle_test dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // watches both channels, predicts every verdict and compares
    pit_verdict_check u_verdict_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 unit clock, low first so the first rising edge is at 4
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // hard stop in case the pipeline hangs or loses a result
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int rand_int(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // sender gap: none in a steady run, else mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            6: return 32767;
            default: return rand_int(-32768, 32767);
        endcase
    endfunction

    // pack absolute coordinates of a, b, c and the point into one test
    function automatic t_pit_in mk(input int ax, input int ay, input int az,
                                   input int bx, input int by, input int bz,
                                   input int cx, input int cy, input int cz,
                                   input int px, input int py, input int pz);
        t_pit_in t;
        t.vertex_a_x = t_coord'(ax);
        t.vertex_a_y = t_coord'(ay);
        t.vertex_a_z = t_coord'(az);
        t.vertex_b_x = t_coord'(bx);
        t.vertex_b_y = t_coord'(by);
        t.vertex_b_z = t_coord'(bz);
        t.vertex_c_x = t_coord'(cx);
        t.vertex_c_y = t_coord'(cy);
        t.vertex_c_z = t_coord'(cz);
        t.point_x    = t_coord'(px);
        t.point_y    = t_coord'(py);
        t.point_z    = t_coord'(pz);
        return t;
    endfunction

    // random test: most often real triangles with points placed by barycentric
    // weights, plus collinear triangles, points on vertices and edges,
    // extreme coordinates and plain noise
    function automatic t_pit_in make_random_test();
        int kind, span, s, u, mb, mc, sel, axis;
        int a[3], b[3], c[3], p[3], d[3];
        bit exact;
        kind  = $urandom_range(0, 99);
        span  = ($urandom_range(0, 3) == 0) ? 8000 : $urandom_range(2, 300);
        exact = $urandom_range(0, 1);
        // a absolute, b and c held as offsets from a for now
        for (int i = 0; i < 3; i++) begin
            a[i] = rand_int(-8000, 8000);
            b[i] = rand_int(-span, span);
            c[i] = rand_int(-span, span);
            if (exact) begin
                // multiples of 16 make the weighted points land exactly
                b[i] = (b[i] / 16) * 16;
                c[i] = (c[i] / 16) * 16;
            end
        end
        if (kind < 45) begin
            s = $urandom_range(0, 16);
            if ($urandom_range(0, 6) == 0)
                s = 0;
            u = $urandom_range(0, 18 - s);
            if ($urandom_range(0, 4) == 0)
                u = 16 - s;  // on the far edge bc
            for (int i = 0; i < 3; i++)
                p[i] = a[i] + (s * b[i] + u * c[i]) / 16;
            // sometimes lift the point off the plane
            if ($urandom_range(0, 2) == 0) begin
                axis = $urandom_range(0, 2);
                p[axis] = p[axis] + rand_int(-span, span);
            end
        end else if (kind < 55) begin
            // collinear or coincident vertices
            mb = rand_int(-5, 5);
            mc = rand_int(-5, 5);
            for (int i = 0; i < 3; i++) begin
                d[i] = rand_int(-200, 200);
                b[i] = mb * d[i];
                c[i] = mc * d[i];
                p[i] = a[i] + rand_int(-400, 400);
            end
        end else if (kind < 65) begin
            // point on a vertex or an edge midpoint
            sel = $urandom_range(0, 4);
            for (int i = 0; i < 3; i++) begin
                case (sel)
                    0: p[i] = a[i];
                    1: p[i] = a[i] + b[i];
                    2: p[i] = a[i] + c[i];
                    3: p[i] = a[i] + (b[i] + c[i]) / 2;
                    default: p[i] = a[i] + b[i] / 2;
                endcase
            end
        end
        for (int i = 0; i < 3; i++) begin
            b[i] = a[i] + b[i];
            c[i] = a[i] + c[i];
        end
        if (kind >= 65 && kind < 80) begin
            for (int i = 0; i < 3; i++) begin
                a[i] = pick_extreme();
                b[i] = pick_extreme();
                c[i] = pick_extreme();
                p[i] = pick_extreme();
            end
        end else if (kind >= 80) begin
            // full-range noise, every bit of every field
            for (int i = 0; i < 3; i++) begin
                a[i] = rand_int(-32768, 32767);
                b[i] = rand_int(-32768, 32767);
                c[i] = rand_int(-32768, 32767);
                p[i] = rand_int(-32768, 32767);
            end
        end
        return mk(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2], p[0], p[1], p[2]);
    endfunction

    // called just after posedge clk; returns just after the posedge that
    // took the transfer, with valid still high for a back-to-back follow-up
    task automatic send_test(input t_pit_in t, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // sender holds off until every outstanding verdict is back
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);  // lets the checker count the last transfer
        while (pending != 0)
            @(posedge clk);
    endtask

    // result side: ready in runs, short stalls mostly, a few long ones
    initial begin
        int  r;
        int  run;
        logic v;
        forever begin
            r = $urandom_range(0, 99);
            if (steady_run === 1'b1) begin
                v   = 1'b1;
                run = 1;
            end else if (r < 65) begin
                v   = 1'b1;
                run = $urandom_range(1, 8);
            end else if (r < 93) begin
                v   = 1'b0;
                run = $urandom_range(1, 4);
            end else begin
                v   = 1'b0;
                run = $urandom_range(15, 40);
            end
            out_ready <= v;
            repeat (run) @(posedge clk);
        end
    end

    initial begin
        t_pit_in directed[$];
        steady_run = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // all vertices and the point coincide
        directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // right triangle in the xy plane: interior, vertices, edge midpoints, one outside
        directed.push_back(mk(0, 0, 0, 100, 0, 0, 0, 100, 0, 10, 10, 0));
        directed.push_back(mk(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, 100, 0, 0, 0, 100, 0, 100, 0, 0));
        directed.push_back(mk(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 100, 0));
        directed.push_back(mk(0, 0, 0, 100, 0, 0, 0, 100, 0, 50, 0, 0));
        directed.push_back(mk(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 50, 0));
        directed.push_back(mk(0, 0, 0, 100, 0, 0, 0, 100, 0, 50, 50, 0));
        directed.push_back(mk(0, 0, 0, 100, 0, 0, 0, 100, 0, 49, 50, 0));
        directed.push_back(mk(0, 0, 0, 100, 0, 0, 0, 100, 0, -1, 5, 0));
        // off the plane, projects inside
        directed.push_back(mk(0, 0, 0, 100, 0, 0, 0, 100, 0, 10, 10, 1000));
        // collinear, and two coincident vertices
        directed.push_back(mk(0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 1, 1));
        directed.push_back(mk(5, 5, 5, 9, -3, 2, 9, -3, 2, 5, 5, 5));
        // full-range coordinates
        directed.push_back(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                              -32768, 32767, -32768, -32768, -32768, -32768));
        directed.push_back(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                              -32768, 32767, -32768, 32767, 32767, 32767));
        directed.push_back(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                              -32768, 32767, -32768, 0, 0, 32767));
        directed.push_back(mk(32767, 32767, 32767, -32768, -32768, 32767,
                              32767, -32768, -32768, 0, 0, 0));
        directed.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768,
                              32767, 32767, 32767, -32768, -32768, -32768));
        directed.push_back(mk(-32768, 32767, -32768, 32767, -32768, 32767,
                              -32768, -32768, 32767, -1, -1, -1));
        directed.push_back(mk(-32768, -32768, 0, 32767, -32768, 0,
                              -32768, 32767, 0, -1, -1, 0));
        // tiny triangle, point exactly on edge bc
        directed.push_back(mk(-1, -1, -1, 1, -1, -1, -1, 1, -1, 0, 0, -1));

        foreach (directed[i])
            send_test(directed[i], pick_gap());

        // pipeline fully drained once before the random part
        wait_until_drained();

        for (int n = 0; n < RANDOM_TESTS; n++) begin
            // every 150 tests pick whether this stretch runs without idling
            if (n % 150 == 0)
                steady_run = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_TESTS / 2)
                wait_until_drained();
            send_test(make_random_test(), pick_gap());
        end
        in_valid <= 1'b0;

        // wait for the last verdicts, then a quiet tail to catch strays
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
